FILE: rtl/rsba_pkg.sv
// Shared types, constants and helper functions of the row slot bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package rsba_pkg;

  // Capacity of the bitmap and the reach of the 10-bit index fields.
  localparam int MAX_ROWS   = 1024;
  localparam int INDEX_SPAN = 1024;
  localparam int LIVE_CAP   = (MAX_ROWS < INDEX_SPAN) ? MAX_ROWS : INDEX_SPAN;

  // Field widths fixed by the interface.
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 10;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 11;

  // Bitmap storage geometry: one memory word holds WORD_W occupancy bits.
  localparam int WORD_W  = (LIVE_CAP < 32) ? LIVE_CAP : 32;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int DEPTH   = (LIVE_CAP + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW_W    = WADDR_W + 1;
  localparam int CNT_W   = $clog2(LIVE_CAP + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_OCCUPY  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_ALLOC   = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK           = 3'd0,
    STAT_NOW_FULL     = 3'd1,
    STAT_OUT_OF_BOUND = 3'd2,
    STAT_OCCUPIED     = 3'd3,
    STAT_EMPTY        = 3'd4,
    STAT_EMPTIED      = 3'd5,
    STAT_WAS_FULL     = 3'd6,
    STAT_NO_FREE      = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  // Summary of one scan over the live part of the bitmap.
  // The counts saturate at two: zero, exactly one, or more.
  typedef struct packed {
    logic [1:0]         free_cnt;
    logic [1:0]         used_cnt;
    logic               ff_found;
    logic [WADDR_W-1:0] ff_addr;
    logic [BIT_W-1:0]   ff_bit;
    logic [WORD_W-1:0]  ff_word;
    logic [WORD_W-1:0]  tgt_word;
  } scan_sum_t;

  // Classifies the number of set bits of a word as zero, one or more.
  function automatic logic [1:0] ones_class(logic [WORD_W-1:0] w);
    logic [1:0] r;
    if (w == '0) begin
      r = 2'd0;
    end else if ((w & (w - 1'b1)) == '0) begin
      r = 2'd1;
    end else begin
      r = 2'd2;
    end
    return r;
  endfunction

  // Adds two saturating counts, capping at two.
  function automatic logic [1:0] sat_add(logic [1:0] a, logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > 3'd2) ? 2'd2 : s[1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rsba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module rsba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rsba_scan.sv
// Scan accumulator: folds bitmap words into free and used counts and captures words.
`timescale 1ns / 1ps
`default_nettype none

module rsba_scan (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clear_i,
  input  wire logic                         word_valid_i,
  input  wire logic [rsba_pkg::WORD_W-1:0]  word_i,
  input  wire logic [rsba_pkg::WADDR_W-1:0] word_addr_i,
  input  wire logic [rsba_pkg::CNT_W-1:0]   live_rows_i,
  input  wire logic [rsba_pkg::WADDR_W-1:0] tgt_addr_i,
  output rsba_pkg::scan_sum_t               sum_o
);

  rsba_pkg::scan_sum_t          sum_q, sum_d;
  logic [rsba_pkg::CNT_W-1:0]   base;
  logic [rsba_pkg::CNT_W-1:0]   lim;
  logic [rsba_pkg::WORD_W-1:0]  live_mask;
  logic [rsba_pkg::WORD_W-1:0]  used_w;
  logic [rsba_pkg::WORD_W-1:0]  free_w;
  logic [rsba_pkg::BIT_W-1:0]   low_free;

  // Mask of the bits of this word that lie below the live row count.
  always_comb begin
    base = rsba_pkg::CNT_W'(word_addr_i) << rsba_pkg::BIT_W;
    lim  = (live_rows_i > base) ? (live_rows_i - base) : '0;
    for (int i = 0; i < rsba_pkg::WORD_W; i++) begin
      live_mask[i] = (rsba_pkg::CNT_W'(i) < lim);
    end
    used_w = word_i & live_mask;
    free_w = ~word_i & live_mask;
  end

  // Lowest free bit of the word.
  always_comb begin
    low_free = '0;
    for (int i = rsba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (free_w[i]) begin
        low_free = rsba_pkg::BIT_W'(i);
      end
    end
  end

  // Accumulate the summary as words arrive from the memory.
  always_comb begin
    sum_d = sum_q;
    if (clear_i) begin
      sum_d = '0;
    end else if (word_valid_i) begin
      sum_d.free_cnt = rsba_pkg::sat_add(sum_q.free_cnt, rsba_pkg::ones_class(free_w));
      sum_d.used_cnt = rsba_pkg::sat_add(sum_q.used_cnt, rsba_pkg::ones_class(used_w));
      if (!sum_q.ff_found && (free_w != '0)) begin
        sum_d.ff_found = 1'b1;
        sum_d.ff_addr  = word_addr_i;
        sum_d.ff_bit   = low_free;
        sum_d.ff_word  = word_i;
      end
      if (word_addr_i == tgt_addr_i) begin
        sum_d.tgt_word = word_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

FILE: rtl/row_slot_bitmap_allocator_top.sv
// Top level of the row slot bitmap allocator: command sequencer, bitmap memory, result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals
// --------  ---------  ---------------------------------------------
// in        input      in_valid_i, in_ready_o, command_i, row_index_i
// out       output     out_valid_o, out_ready_i, status_o, slot_index_o
// config    input      row_count_we_i, row_count_i
//
// Each command reads the live words (row count capped at 1024, 32 slots a word)
// one per cycle through the single read port. The sequencer then passes through a
// drain state and a finish state, which registers the result and returns to idle
// for the next transfer; at zero rows no word is read and it goes straight to finish.
// Reset clears the per-word valid bits at once, so there is no clearing pass.
// A command is taken while a result waits; its write-back and result then hold.

module row_slot_bitmap_allocator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rsba_pkg::CMD_W-1:0]    command_i,
  input  wire logic [rsba_pkg::IDX_W-1:0]    row_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [rsba_pkg::STATUS_W-1:0] status_o,
  output logic      [rsba_pkg::IDX_W-1:0]    slot_index_o,
  input  wire logic                          row_count_we_i,
  input  wire logic [rsba_pkg::CFG_W-1:0]    row_count_i
);

  rsba_pkg::state_e              state_q, state_d;
  logic [rsba_pkg::CFG_W-1:0]    row_count_q;
  rsba_pkg::cmd_e                cmd_q;
  logic [rsba_pkg::IDX_W-1:0]    idx_q;
  logic [rsba_pkg::WADDR_W-1:0]  rd_addr_q, rd_addr_d;
  logic                          rd_pend_q;
  logic [rsba_pkg::WADDR_W-1:0]  rd_pend_addr_q;
  logic                          rd_vld_q;
  logic [rsba_pkg::DEPTH-1:0]    word_vld_q;
  logic                          out_valid_q;
  logic [rsba_pkg::STATUS_W-1:0] status_q;
  logic [rsba_pkg::IDX_W-1:0]    slot_q;

  logic [rsba_pkg::CNT_W-1:0]    live_rows;
  logic [rsba_pkg::CNT_W:0]      nw_full;
  logic [rsba_pkg::NW_W-1:0]     num_words;
  logic                          accept;
  logic                          issue;
  logic                          last_issue;
  logic [rsba_pkg::WORD_W-1:0]   rd_data;
  logic [rsba_pkg::WORD_W-1:0]   word_eff;
  logic [rsba_pkg::WADDR_W-1:0]  tgt_addr;
  logic [rsba_pkg::BIT_W-1:0]    tgt_bit;
  rsba_pkg::scan_sum_t           sum;
  logic                          finish;
  logic                          wr_en;
  logic [rsba_pkg::WADDR_W-1:0]  wr_addr;
  logic [rsba_pkg::WORD_W-1:0]   wr_data;
  rsba_pkg::status_e             res_status;
  logic [rsba_pkg::IDX_W-1:0]    res_slot;
  logic                          in_bound;
  logic                          tgt_set;
  logic [rsba_pkg::WORD_W-1:0]   tgt_onehot;
  logic [rsba_pkg::WORD_W-1:0]   ff_onehot;

  // Effective row count, capped at the bitmap capacity, and words to scan.
  always_comb begin
    if (row_count_q > rsba_pkg::CFG_W'(rsba_pkg::LIVE_CAP)) begin
      live_rows = rsba_pkg::CNT_W'(rsba_pkg::LIVE_CAP);
    end else begin
      live_rows = row_count_q[rsba_pkg::CNT_W-1:0];
    end
    nw_full   = ({1'b0, live_rows} + (rsba_pkg::CNT_W + 1)'(rsba_pkg::WORD_W - 1))
                >> rsba_pkg::BIT_W;
    num_words = nw_full[rsba_pkg::NW_W-1:0];
  end

  assign in_ready_o = (state_q == rsba_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign issue      = (state_q == rsba_pkg::S_SCAN);
  assign last_issue = ((rsba_pkg::NW_W'(rd_addr_q) + 1'b1) == num_words);
  assign finish     = (state_q == rsba_pkg::S_FINISH) && (!out_valid_q || out_ready_i);

  // Sequencer: scan the live words, then write back and post the result.
  always_comb begin
    state_d   = state_q;
    rd_addr_d = rd_addr_q;
    case (state_q)
      rsba_pkg::S_IDLE: begin
        rd_addr_d = '0;
        if (accept) begin
          state_d = (num_words == '0) ? rsba_pkg::S_FINISH : rsba_pkg::S_SCAN;
        end
      end
      rsba_pkg::S_SCAN: begin
        if (last_issue) begin
          state_d = rsba_pkg::S_DRAIN;
        end else begin
          rd_addr_d = rd_addr_q + 1'b1;
        end
      end
      rsba_pkg::S_DRAIN: begin
        state_d = rsba_pkg::S_FINISH;
      end
      rsba_pkg::S_FINISH: begin
        if (finish) begin
          state_d = rsba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rsba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rsba_pkg::S_IDLE;
      rd_addr_q <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_addr_q <= rd_addr_d;
      rd_pend_q <= issue;
    end
  end

  // Command capture and read bookkeeping.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= rsba_pkg::cmd_e'(command_i);
      idx_q <= row_index_i;
    end
    if (issue) begin
      rd_pend_addr_q <= rd_addr_q;
      rd_vld_q       <= word_vld_q[rd_addr_q];
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= rsba_pkg::CFG_W'(1024);
    end else if (row_count_we_i) begin
      row_count_q <= row_count_i;
    end
  end

  // Per-word valid bits: a word never written reads as all free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= '0;
    end else if (wr_en) begin
      word_vld_q[wr_addr] <= 1'b1;
    end
  end

  rsba_ram #(
    .WIDTH(rsba_pkg::WORD_W),
    .DEPTH(rsba_pkg::DEPTH)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (issue),
    .raddr_i(rd_addr_q),
    .rdata_o(rd_data)
  );

  assign word_eff = rd_vld_q ? rd_data : '0;
  assign tgt_addr = idx_q[rsba_pkg::BIT_W+rsba_pkg::WADDR_W-1:rsba_pkg::BIT_W];
  assign tgt_bit  = idx_q[rsba_pkg::BIT_W-1:0];

  rsba_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (accept),
    .word_valid_i(rd_pend_q),
    .word_i      (word_eff),
    .word_addr_i (rd_pend_addr_q),
    .live_rows_i (live_rows),
    .tgt_addr_i  (tgt_addr),
    .sum_o       (sum)
  );

  // Decide the result and the write-back from the scan summary.
  always_comb begin
    in_bound   = (rsba_pkg::CNT_W'(idx_q) < live_rows)
                 && ({{(rsba_pkg::CNT_W){1'b0}}, idx_q} < {{(rsba_pkg::IDX_W){1'b0}}, live_rows});
    tgt_onehot = rsba_pkg::WORD_W'(1) << tgt_bit;
    ff_onehot  = rsba_pkg::WORD_W'(1) << sum.ff_bit;
    tgt_set    = sum.tgt_word[tgt_bit];
    wr_en      = 1'b0;
    wr_addr    = tgt_addr;
    wr_data    = sum.tgt_word;
    res_slot   = idx_q;
    res_status = rsba_pkg::STAT_OK;
    if (cmd_q == rsba_pkg::CMD_ALLOC) begin
      if (!sum.ff_found) begin
        res_status = rsba_pkg::STAT_NO_FREE;
        res_slot   = '0;
      end else begin
        wr_en      = finish;
        wr_addr    = sum.ff_addr;
        wr_data    = sum.ff_word | ff_onehot;
        res_slot   = rsba_pkg::IDX_W'({sum.ff_addr, sum.ff_bit});
        res_status = (sum.free_cnt == 2'd1) ? rsba_pkg::STAT_NOW_FULL : rsba_pkg::STAT_OK;
      end
    end else if (!in_bound) begin
      res_status = rsba_pkg::STAT_OUT_OF_BOUND;
    end else begin
      case (cmd_q)
        rsba_pkg::CMD_OCCUPY: begin
          if (tgt_set) begin
            res_status = rsba_pkg::STAT_OCCUPIED;
          end else begin
            wr_en      = finish;
            wr_data    = sum.tgt_word | tgt_onehot;
            res_status = (sum.free_cnt == 2'd1) ? rsba_pkg::STAT_NOW_FULL
                                                : rsba_pkg::STAT_OK;
          end
        end
        rsba_pkg::CMD_RELEASE: begin
          if (!tgt_set) begin
            res_status = rsba_pkg::STAT_EMPTY;
          end else begin
            wr_en   = finish;
            wr_data = sum.tgt_word & ~tgt_onehot;
            if (sum.used_cnt == 2'd1) begin
              res_status = rsba_pkg::STAT_EMPTIED;
            end else if (sum.free_cnt == 2'd0) begin
              res_status = rsba_pkg::STAT_WAS_FULL;
            end else begin
              res_status = rsba_pkg::STAT_OK;
            end
          end
        end
        default: begin
          res_status = tgt_set ? rsba_pkg::STAT_OK : rsba_pkg::STAT_EMPTY;
        end
      endcase
    end
  end

  // Result register: parts the output channel from the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_q <= res_status;
      slot_q   <= res_slot;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_index_o = slot_q;

endmodule

`default_nettype wire
